### sv/vertex_transform_divide_assert.svh
// Assertion macros shared by the vertex transform RTL.
// Each macro expects clk and rst in scope; no other dependencies.
`ifndef VERTEX_TRANSFORM_DIVIDE_ASSERT_SVH
`define VERTEX_TRANSFORM_DIVIDE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define VTD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define VTD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/vtd_pkg.sv
// Shared types and constants for the vertex transform and divide block.
// No dependencies; used by vtd_div and vertex_transform_divide.
`timescale 1ns / 1ps

package vtd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QUO_BITS  = 32;
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W     = 64;
  localparam int COORD_W   = 32;

  typedef enum logic [1:0] {
    FUNC_SCREEN = 2'd0,
    FUNC_DIV3   = 2'd1,
    FUNC_DIV4   = 2'd2,
    FUNC_NODIV  = 2'd3
  } func_t;

  typedef struct packed {
    func_t               func;
    logic [COORD_W-1:0]  in_x;
    logic [COORD_W-1:0]  in_y;
    logic [COORD_W-1:0]  in_z;
    logic [COORD_W-1:0]  in_w;
  } vtx_t;

  typedef struct packed {
    logic [COORD_W-1:0]  out_x;
    logic [COORD_W-1:0]  out_y;
    logic [COORD_W-1:0]  out_z;
    logic [COORD_W-1:0]  out_w;
    logic                saturated;
  } res_t;

  // Result of one divider lane.
  typedef struct packed {
    logic                sat;
    logic [QUO_BITS-1:0] q;
  } div_res_t;

  // Undivided values carried alongside the divider lanes.
  typedef struct packed {
    func_t               func;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [COORD_W-1:0]  z;
    logic [COORD_W-1:0]  w;
    logic                sat;
  } pass_t;

endpackage

### sv/vtd_div.sv
// Pipelined restoring divider lane: round(num * 2^F / den), saturated to 32 bits.
// Depends on vtd_pkg; instantiated by vertex_transform_divide.
`timescale 1ns / 1ps

module vtd_div #(
  parameter int FRAC_BITS = vtd_pkg::FRAC_BITS,
  parameter int NW        = 66 - vtd_pkg::FRAC_BITS
) (
  input  logic              clk,
  input  logic              en,
  input  logic [NW-1:0]     num,
  input  logic [NW-1:0]     den,
  input  logic              neg,
  output vtd_pkg::div_res_t res
);

  localparam int QB = vtd_pkg::QUO_BITS;
  localparam int RW = NW + QB;

  logic [RW-1:0] rem [QB+1];
  logic [NW-1:0] dsr [QB+1];
  logic          ng  [QB+1];
  logic          ov  [QB+1];
  logic [QB-1:0] quo [QB+1];

  // Entry stage: scale the dividend and flag quotients of 2^32 or more.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= RW'(num) << FRAC_BITS;
      dsr[0] <= den;
      ng[0]  <= neg;
      ov[0]  <= (RW'(num) << FRAC_BITS) >= (RW'(den) << QB);
      quo[0] <= '0;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 0; k < QB; k++) begin : g_step
    localparam int SH = QB - 1 - k;
    logic [RW-1:0] ds;
    logic          ge;
    assign ds = RW'(dsr[k]) << SH;
    assign ge = rem[k] >= ds;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? rem[k] - ds : rem[k];
        quo[k+1] <= {quo[k][QB-2:0], ge};
        dsr[k+1] <= dsr[k];
        ng[k+1]  <= ng[k];
        ov[k+1]  <= ov[k];
      end
    end
  end

  // Round half away from zero, apply the sign and clamp.
  logic          rnd;
  logic [QB:0]   mag;
  logic [QB:0]   lim;
  logic          sat;
  logic [QB-1:0] val;

  always_comb begin
    rnd = ({1'b0, rem[QB]} << 1) >= (RW+1)'(dsr[QB]);
    mag = (QB+1)'(quo[QB]) + (QB+1)'(rnd);
    lim = (QB+1)'(1) << (QB-1);
    sat = ov[QB] || (ng[QB] ? (mag > lim) : (mag >= lim));
    if (sat) begin
      val = ng[QB] ? {1'b1, {(QB-1){1'b0}}} : {1'b0, {(QB-1){1'b1}}};
    end else begin
      val = ng[QB] ? QB'(-mag) : mag[QB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.sat <= sat;
      res.q   <= val;
    end
  end

endmodule

### sv/vertex_transform_divide.sv
// Vertex transform with perspective divide. Takes one vertex request per clock
// while the output is not stalled, and returns one result per accepted request.
// Every stage is registered: 1 input stage, 1 multiply stage (sixteen 32x32
// products), 2 adder stages, 1 prepare stage, and four divider lanes of 34
// stages each that retire one quotient bit per stage. The whole pipeline holds
// while a finished result is stalled at the output. The user must write the matrix
// registers through the cfg port only while no request is in flight (not enforced).
// Depends on vtd_pkg, vtd_div and vertex_transform_divide_assert.svh.
`timescale 1ns / 1ps

`include "vertex_transform_divide_assert.svh"

module vertex_transform_divide #(
  parameter int FRAC_BITS = vtd_pkg::FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           vtx_valid,
  output logic                           vtx_stall,
  input  vtd_pkg::vtx_t                  vtx,
  output logic                           res_valid,
  input  logic                           res_stall,
  output vtd_pkg::res_t                  res,
  input  logic                           cfg_we,
  input  logic [vtd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vtd_pkg::CFG_W-1:0]      cfg_data
);

  localparam int CW       = vtd_pkg::COORD_W;
  localparam int DW       = 66 - FRAC_BITS;
  localparam int LANE_LAT = vtd_pkg::QUO_BITS + 2;
  localparam int PRE      = 5;
  localparam int NSTG     = PRE + LANE_LAT;

  localparam logic [CW-1:0]          ONE_C  = CW'(1) << FRAC_BITS;
  localparam logic [DW-1:0]          ONE_D  = DW'(1) << FRAC_BITS;
  localparam logic signed [65:0]     HALF   = 66'(1) << (FRAC_BITS - 1);
  localparam logic signed [DW-1:0]   SMAX   = DW'(32'sh7fffffff);
  localparam logic signed [DW-1:0]   SMIN   = DW'(32'sh80000000);

  // Matrix registers, reset to identity.
  logic [vtd_pkg::CFG_W-1:0] mreg [vtd_pkg::NUM_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      mreg[0] <= 64'(ONE_C);
      mreg[1] <= '0;
      mreg[2] <= 64'(ONE_C) << 32;
      mreg[3] <= '0;
      mreg[4] <= '0;
      mreg[5] <= 64'(ONE_C);
      mreg[6] <= '0;
      mreg[7] <= 64'(ONE_C) << 32;
    end else if (cfg_we && (cfg_index < vtd_pkg::CFG_IDX_W'(vtd_pkg::NUM_REGS))) begin
      mreg[cfg_index[2:0]] <= cfg_data;
    end
  end

  // Global advance: everything moves unless a finished result is held.
  logic              en;
  logic [NSTG-1:0]   vld;
  vtd_pkg::func_t    res_func;

  assign en        = !(res_valid && res_stall);
  assign vtx_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      res_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[NSTG-2:0], vtx_valid};
      res_valid <= vld[NSTG-1];
    end
  end

  // Input stage; w is 1.0 unless the request skips the divide.
  vtd_pkg::func_t         f1;
  logic signed [CW-1:0]   v1 [4];

  always_ff @(posedge clk) begin
    if (en) begin
      f1    <= vtx.func;
      v1[0] <= vtx.in_x;
      v1[1] <= vtx.in_y;
      v1[2] <= vtx.in_z;
      v1[3] <= (vtx.func == vtd_pkg::FUNC_NODIV) ? vtx.in_w : ONE_C;
    end
  end

  // Multiply stage: sixteen products, row r weights input component r.
  vtd_pkg::func_t         f2;
  logic signed [63:0]     prod [4][4];

  always_ff @(posedge clk) begin
    if (en) begin
      f2 <= f1;
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      logic signed [CW-1:0] m;
      assign m = (c % 2 == 1) ? mreg[2*r + c/2][63:32] : mreg[2*r + c/2][31:0];
      always_ff @(posedge clk) begin
        if (en) begin
          prod[r][c] <= 64'(v1[r]) * 64'(m);
        end
      end
    end
  end

  // Adder stages: pairwise sums, then the full sum rounded half up.
  vtd_pkg::func_t         f3, f4;
  logic signed [64:0]     psa [4];
  logic signed [64:0]     psb [4];
  logic signed [DW-1:0]   dot [4];

  always_ff @(posedge clk) begin
    if (en) begin
      f3 <= f2;
      f4 <= f3;
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_sum
    logic signed [65:0] full;
    assign full = 66'(psa[c]) + 66'(psb[c]) + HALF;
    always_ff @(posedge clk) begin
      if (en) begin
        psa[c] <= 65'(prod[0][c]) + 65'(prod[1][c]);
        psb[c] <= 65'(prod[2][c]) + 65'(prod[3][c]);
        dot[c] <= DW'(full >>> FRAC_BITS);
      end
    end
  end

  // Prepare stage: zero-w fix, magnitudes and signs, undivided saturation.
  // The lanes always see a nonzero divisor; their results are unused when
  // the request skips the divide.
  logic signed [DW-1:0]   wd;
  logic signed [DW-1:0]   znum;
  logic                   rawsat [4];
  logic [CW-1:0]          rawv   [4];
  vtd_pkg::pass_t         pre;
  logic [DW-1:0]          num_n  [4];
  logic                   num_s  [4];
  logic [DW-1:0]          rcp_den;
  logic                   den_s;

  always_comb begin
    wd   = (dot[3] == '0) ? ONE_D : dot[3];
    znum = (f4 == vtd_pkg::FUNC_SCREEN) ? ONE_D : dot[2];
  end

  for (genvar c = 0; c < 4; c++) begin : g_raw
    always_comb begin
      rawsat[c] = (dot[c] > SMAX) || (dot[c] < SMIN);
      if (dot[c] > SMAX) begin
        rawv[c] = {1'b0, {(CW-1){1'b1}}};
      end else if (dot[c] < SMIN) begin
        rawv[c] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        rawv[c] = dot[c][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre.func <= f4;
      pre.x    <= rawv[0];
      pre.y    <= rawv[1];
      pre.z    <= rawv[2];
      pre.w    <= rawv[3];
      pre.sat  <= rawsat[0] | rawsat[1] | rawsat[2] | rawsat[3];
      num_n[0] <= dot[0][DW-1] ? DW'(-dot[0]) : dot[0];
      num_s[0] <= dot[0][DW-1];
      num_n[1] <= dot[1][DW-1] ? DW'(-dot[1]) : dot[1];
      num_s[1] <= dot[1][DW-1];
      num_n[2] <= znum[DW-1] ? DW'(-znum) : znum;
      num_s[2] <= znum[DW-1];
      num_n[3] <= ONE_D;
      num_s[3] <= 1'b0;
      rcp_den  <= wd[DW-1] ? DW'(-wd) : wd;
      den_s    <= wd[DW-1];
    end
  end

  // Divider lanes: x, y, z (or 1/w in screen mode), and 1/w.
  vtd_pkg::div_res_t lane [4];

  for (genvar c = 0; c < 4; c++) begin : g_lane
    vtd_div #(
      .FRAC_BITS(FRAC_BITS),
      .NW       (DW)
    ) u_div (
      .clk (clk),
      .en  (en),
      .num (num_n[c]),
      .den (rcp_den),
      .neg (num_s[c] ^ den_s),
      .res (lane[c])
    );
  end

  // Undivided values and mode travel beside the lanes.
  vtd_pkg::pass_t dl [LANE_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      dl[0] <= pre;
    end
  end

  for (genvar k = 1; k < LANE_LAT; k++) begin : g_dl
    always_ff @(posedge clk) begin
      if (en) begin
        dl[k] <= dl[k-1];
      end
    end
  end

  // Output register: pick divided or undivided results by mode.
  vtd_pkg::pass_t pend;
  vtd_pkg::res_t  res_next;

  assign pend = dl[LANE_LAT-1];

  always_comb begin
    case (pend.func)
      vtd_pkg::FUNC_NODIV: begin
        res_next.out_x     = pend.x;
        res_next.out_y     = pend.y;
        res_next.out_z     = pend.z;
        res_next.out_w     = pend.w;
        res_next.saturated = pend.sat;
      end
      vtd_pkg::FUNC_DIV4: begin
        res_next.out_x     = lane[0].q;
        res_next.out_y     = lane[1].q;
        res_next.out_z     = lane[2].q;
        res_next.out_w     = lane[3].q;
        res_next.saturated = lane[0].sat | lane[1].sat | lane[2].sat | lane[3].sat;
      end
      default: begin
        res_next.out_x     = lane[0].q;
        res_next.out_y     = lane[1].q;
        res_next.out_z     = lane[2].q;
        res_next.out_w     = '0;
        res_next.saturated = lane[0].sat | lane[1].sat | lane[2].sat;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res      <= res_next;
      res_func <= pend.func;
    end
  end

  // Modes that return three outputs leave w at zero.
  logic res_three;

  assign res_three = res_valid &&
                     (res_func == vtd_pkg::FUNC_SCREEN || res_func == vtd_pkg::FUNC_DIV3);

  // Checks on pipeline control and the divide path.
  `VTD_ASSERT_NEXT(a_vld_shift, en, vld[1] == $past(vld[0]), "valid bit lost in pipeline")
  `VTD_ASSERT_IMPL(a_den_nonzero, vld[PRE-1], rcp_den != '0, "zero divisor reached lanes")
  `VTD_ASSERT_IMPL(a_w_zero, res_three, res.out_w == '0, "out_w not zero in three-output mode")

endmodule

### bench/vertex_transform_divide_tb.sv
// Self-checking testbench for vertex_transform_divide: a directed table, then
// random vertices under several matrix settings and idle patterns.
// Depends on vtd_pkg and the vertex_transform_divide RTL.
`timescale 1ns / 1ps

module vertex_transform_divide_tb;

  localparam longint ONE_Q = 64'sd1 << vtd_pkg::FRAC_BITS;
  localparam int DRAIN_CYCLES = 48;
  localparam int SEG_ITEMS = 175;
  localparam int NUM_SEGS = 10;

  typedef struct {
    bit            is_cfg;
    logic [3:0]    idx;
    logic [63:0]   data;
    vtd_pkg::vtx_t vert;
    bit            has_exp;
    vtd_pkg::res_t exp;
  } stim_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          vtx_valid = 1'b0;
  logic                          vtx_stall;
  vtd_pkg::vtx_t                 vtx = '0;
  logic                          res_valid;
  logic                          res_stall = 1'b0;
  vtd_pkg::res_t                 res;
  logic                          cfg_we = 1'b0;
  logic [vtd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [vtd_pkg::CFG_W-1:0]     cfg_data = '0;

  // Local copy of the matrix registers, reset to identity.
  logic [63:0] matrix [8] = '{64'h10000, 64'h0, 64'h1_0000_0000_0000, 64'h0,
                              64'h0, 64'h10000, 64'h0, 64'h1_0000_0000_0000};
  vtd_pkg::res_t pending_results [$];
  int            errors = 0;
  int            send_idle_pct = 0;
  int            stall_pct = 0;

  vertex_transform_divide dut (
    .clk(clk), .rst(rst),
    .vtx_valid(vtx_valid), .vtx_stall(vtx_stall), .vtx(vtx),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Matrix element for input row r and output column c.
  function automatic longint mat_elem(int r, int c);
    logic [63:0] w;
    w = matrix[2 * r + c / 2];
    return (c % 2) ? longint'($signed(w[63:32])) : longint'($signed(w[31:0]));
  endfunction

  // Exact row-vector dot product with one column, rounded half up.
  function automatic longint column_sum(longint comp [4], int c);
    logic signed [79:0] acc;
    logic signed [79:0] a;
    logic signed [79:0] b;
    acc = '0;
    for (int r = 0; r < 4; r++) begin
      a = comp[r];
      b = mat_elem(r, c);
      acc += a * b;
    end
    acc = (acc + (80'sd1 <<< (vtd_pkg::FRAC_BITS - 1))) >>> vtd_pkg::FRAC_BITS;
    return longint'(acc[63:0]);
  endfunction

  // Rounded fixed-point quotient, half away from zero; huge values are capped.
  function automatic longint fixed_div(longint num, longint den);
    logic [127:0] n;
    logic [127:0] d;
    logic [127:0] q;
    logic [127:0] rm;
    n = (num < 0) ? 128'(-num) : 128'(num);
    d = (den < 0) ? 128'(-den) : 128'(den);
    n = n << vtd_pkg::FRAC_BITS;
    q = n / d;
    rm = n % d;
    if (rm * 2 >= d) q++;
    if (q > (128'd1 << 40)) q = 128'd1 << 40;
    return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [31:0] clamp32(longint v, ref bit clipped);
    if (v > 64'sd2147483647) begin
      clipped = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Expected result of one vertex under the current matrix.
  function automatic vtd_pkg::res_t transform_vertex(vtd_pkg::vtx_t v);
    longint        comp [4];
    longint        nx, ny, nz, nw;
    bit            clipped;
    vtd_pkg::res_t r;
    clipped = 1'b0;
    comp[0] = $signed(v.in_x);
    comp[1] = $signed(v.in_y);
    comp[2] = $signed(v.in_z);
    comp[3] = (v.func == vtd_pkg::FUNC_NODIV) ? longint'($signed(v.in_w)) : ONE_Q;
    nx = column_sum(comp, 0);
    ny = column_sum(comp, 1);
    nz = column_sum(comp, 2);
    nw = column_sum(comp, 3);
    if (v.func == vtd_pkg::FUNC_NODIV) begin
      r.out_x = clamp32(nx, clipped);
      r.out_y = clamp32(ny, clipped);
      r.out_z = clamp32(nz, clipped);
      r.out_w = clamp32(nw, clipped);
    end else begin
      // A zero w would blow up the divide, so it stands in as one.
      if (nw == 0) nw = ONE_Q;
      r.out_x = clamp32(fixed_div(nx, nw), clipped);
      r.out_y = clamp32(fixed_div(ny, nw), clipped);
      if (v.func == vtd_pkg::FUNC_SCREEN) r.out_z = clamp32(fixed_div(ONE_Q, nw), clipped);
      else r.out_z = clamp32(fixed_div(nz, nw), clipped);
      if (v.func == vtd_pkg::FUNC_DIV4) r.out_w = clamp32(fixed_div(ONE_Q, nw), clipped);
      else r.out_w = '0;
    end
    r.saturated = clipped;
    return r;
  endfunction

  function automatic vtd_pkg::vtx_t make_vtx(vtd_pkg::func_t f, logic [31:0] x,
                                             logic [31:0] y, logic [31:0] z,
                                             logic [31:0] w);
    vtd_pkg::vtx_t v;
    v.func = f;
    v.in_x = x;
    v.in_y = y;
    v.in_z = z;
    v.in_w = w;
    return v;
  endfunction

  function automatic stim_row_t vtx_row(vtd_pkg::vtx_t v, bit has_exp,
                                        vtd_pkg::res_t exp);
    stim_row_t s;
    s.is_cfg = 1'b0;
    s.idx = '0;
    s.data = '0;
    s.vert = v;
    s.has_exp = has_exp;
    s.exp = exp;
    return s;
  endfunction

  function automatic stim_row_t cfg_row(logic [3:0] idx, logic [63:0] data);
    stim_row_t s;
    s = vtx_row('0, 1'b0, '0);
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.data = data;
    return s;
  endfunction

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(99) < 75) return 32'($urandom_range(32'h20_0000) - 32'h10_0000);
    return $urandom;
  endfunction

  // Random register value: full random, small elements, or plain identity.
  function automatic logic [63:0] rand_reg(int idx);
    case ($urandom_range(2))
      0: return {$urandom, $urandom};
      1: return {32'($urandom_range(32'h4_0000) - 32'h2_0000),
                 32'($urandom_range(32'h4_0000) - 32'h2_0000)};
      default: return (idx % 2 == 0) ? ((idx == 0) ? 64'h10000 :
                       (idx == 2) ? 64'h1_0000_0000_0000 : 64'h0) :
                       ((idx == 5) ? 64'h10000 : (idx == 7) ? 64'h1_0000_0000_0000 : 64'h0);
    endcase
  endfunction

  // Present one vertex request and record its expected result on acceptance.
  task automatic send_vertex(vtd_pkg::vtx_t v, bit has_exp, vtd_pkg::res_t exp);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      vtx_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vtx_valid <= 1'b1;
    vtx <= v;
    @(posedge clk);
    while (vtx_stall) @(posedge clk);
    pending_results.push_back(has_exp ? exp : transform_vertex(v));
  endtask

  // Let the pipeline empty so the matrix can be rewritten safely.
  task automatic drain();
    vtx_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx < vtd_pkg::NUM_REGS) matrix[idx] = data;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver back-pressure for the current idle pattern.
  always @(posedge clk) begin
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    vtd_pkg::res_t e;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: %h", res);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (res.out_x !== e.out_x) begin
          $error("out_x expected %h got %h", e.out_x, res.out_x);
          errors++;
        end
        if (res.out_y !== e.out_y) begin
          $error("out_y expected %h got %h", e.out_y, res.out_y);
          errors++;
        end
        if (res.out_z !== e.out_z) begin
          $error("out_z expected %h got %h", e.out_z, res.out_z);
          errors++;
        end
        if (res.out_w !== e.out_w) begin
          $error("out_w expected %h got %h", e.out_w, res.out_w);
          errors++;
        end
        if (res.saturated !== e.saturated) begin
          $error("saturated expected %b got %b", e.saturated, res.saturated);
          errors++;
        end
      end
    end
  end

  // Main stimulus.
  initial begin
    stim_row_t     table_rows [$];
    vtd_pkg::res_t r;
    logic [63:0]   fill;
    int            idle_mode;

    // Identity matrix after reset: results can be read straight off.
    r = '{32'h10000, 32'h20000, 32'h30000, 32'h10000, 1'b0};
    table_rows.push_back(vtx_row(make_vtx(vtd_pkg::FUNC_NODIV, 32'h10000, 32'h20000,
                                          32'h30000, 32'h10000), 1'b1, r));
    r = '{32'h20000, 32'hFFFF0000, 32'h8000, 32'h0, 1'b0};
    table_rows.push_back(vtx_row(make_vtx(vtd_pkg::FUNC_DIV3, 32'h20000, 32'hFFFF0000,
                                          32'h8000, 32'h5), 1'b1, r));
    r = '{32'h20000, 32'hFFFF0000, 32'h10000, 32'h0, 1'b0};
    table_rows.push_back(vtx_row(make_vtx(vtd_pkg::FUNC_SCREEN, 32'h20000, 32'hFFFF0000,
                                          32'h8000, 32'h0), 1'b1, r));
    r = '{32'h20000, 32'hFFFF0000, 32'h8000, 32'h10000, 1'b0};
    table_rows.push_back(vtx_row(make_vtx(vtd_pkg::FUNC_DIV4, 32'h20000, 32'hFFFF0000,
                                          32'h8000, 32'hFFFFFFFF), 1'b1, r));
    r = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0};
    table_rows.push_back(vtx_row(make_vtx(vtd_pkg::FUNC_NODIV, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                          32'h7FFFFFFF, 32'h7FFFFFFF), 1'b1, r));
    r = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0};
    table_rows.push_back(vtx_row(make_vtx(vtd_pkg::FUNC_NODIV, 32'h80000000, 32'h80000000,
                                          32'h80000000, 32'h80000000), 1'b1, r));
    r = '{32'h0, 32'h0, 32'h0, 32'h10000, 1'b0};
    table_rows.push_back(vtx_row(make_vtx(vtd_pkg::FUNC_DIV4, 32'h0, 32'h0, 32'h0, 32'h0),
                                 1'b1, r));

    // Projection: w output follows input z, so z picks the divisor.
    table_rows.push_back(cfg_row(4'd0, 64'h10000));
    table_rows.push_back(cfg_row(4'd1, 64'h0));
    table_rows.push_back(cfg_row(4'd2, 64'h1_0000_0000_0000));
    table_rows.push_back(cfg_row(4'd3, 64'h0));
    table_rows.push_back(cfg_row(4'd4, 64'h0));
    table_rows.push_back(cfg_row(4'd5, 64'h1_0000_0001_0000));
    table_rows.push_back(cfg_row(4'd6, 64'h0));
    table_rows.push_back(cfg_row(4'd7, 64'h10000));
    // An index past the last register must be ignored.
    table_rows.push_back(cfg_row(4'd15, 64'hFFFF_FFFF_FFFF_FFFF));
    // Zero divisor, tiny divisor (saturation), negative divisor, every mode.
    table_rows.push_back(vtx_row(make_vtx(vtd_pkg::FUNC_DIV3, 32'h30000, 32'h50000,
                                          32'h0, 32'h0), 1'b0, '0));
    table_rows.push_back(vtx_row(make_vtx(vtd_pkg::FUNC_SCREEN, 32'h7FFFFFFF,
                                          32'h80000000, 32'h1, 32'h0), 1'b0, '0));
    table_rows.push_back(vtx_row(make_vtx(vtd_pkg::FUNC_DIV4, 32'h12345, 32'hFFFE0000,
                                          32'hFFFF8000, 32'h0), 1'b0, '0));
    table_rows.push_back(vtx_row(make_vtx(vtd_pkg::FUNC_DIV4, 32'h80000000, 32'h7FFFFFFF,
                                          32'h80000000, 32'h0), 1'b0, '0));
    table_rows.push_back(vtx_row(make_vtx(vtd_pkg::FUNC_NODIV, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                          32'h7FFFFFFF, 32'h7FFFFFFF), 1'b0, '0));
    table_rows.push_back(vtx_row(make_vtx(vtd_pkg::FUNC_DIV3, 32'h10000, 32'h10000,
                                          32'h30000, 32'h0), 1'b0, '0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (table_rows[i]) begin
      if (table_rows[i].is_cfg) begin
        drain();
        write_reg(table_rows[i].idx, table_rows[i].data);
      end else begin
        send_vertex(table_rows[i].vert, table_rows[i].has_exp, table_rows[i].exp);
      end
    end

    // Random segments, each with its own matrix and idle pattern.
    for (int s = 0; s < NUM_SEGS; s++) begin
      drain();
      idle_mode = s % 4;
      send_idle_pct = (idle_mode == 1) ? 70 : (idle_mode == 3) ? 38 : 0;
      stall_pct = (idle_mode == 2) ? 70 : (idle_mode == 3) ? 38 : 0;
      case (s)
        0: fill = 64'h8000_0000_8000_0000;
        1: fill = 64'h7FFF_FFFF_7FFF_FFFF;
        2: fill = 64'h0;
        3: fill = 64'hFFFF_FFFF_FFFF_FFFF;
        default: fill = '0;
      endcase
      for (int k = 0; k < vtd_pkg::NUM_REGS; k++) begin
        write_reg(4'(k), (s < 4) ? fill : rand_reg(k));
      end
      if ($urandom_range(1)) write_reg(4'($urandom_range(15, 8)), {$urandom, $urandom});
      for (int n = 0; n < SEG_ITEMS; n++) begin
        send_vertex(make_vtx(vtd_pkg::func_t'($urandom_range(3)), rand_coord(),
                             rand_coord(), rand_coord(), rand_coord()), 1'b0, '0);
      end
    end

    drain();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("vertex_transform_divide_tb: PASS");
    end else begin
      $display("vertex_transform_divide_tb: FAIL");
    end
    $finish;
  end

  // Watchdog for a hung pipeline.
  initial begin
    #2000000;
    $display("vertex_transform_divide_tb: FAIL");
    $finish;
  end

endmodule
